### rtl/icr_pkg.sv
// Package with the shared types, codes and constants of the image chunk reassembler.
package icr_pkg;

  // Default size of the image store in bytes.
  localparam int unsigned BUFFER_BYTES_DEF = 65536;

  // Entries of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Width of the write position and of the reported image length.
  localparam int unsigned POS_W = 17;

  // Reset value of the idle timeout in milliseconds.
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_HEADER = 2'd0;
  localparam func_t FUNC_DATA   = 2'd1;
  localparam func_t FUNC_TICK   = 2'd2;
  localparam func_t FUNC_READ   = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_IDLE     = 3'd0;
  localparam status_t ST_HDR_OK   = 3'd1;
  localparam status_t ST_HDR_REJ  = 3'd2;
  localparam status_t ST_STORED   = 3'd3;
  localparam status_t ST_IGNORED  = 3'd4;
  localparam status_t ST_COMPLETE = 3'd5;
  localparam status_t ST_TIMEOUT  = 3'd6;
  localparam status_t ST_READ     = 3'd7;

  // One classified input word as it waits in the queue.
  typedef struct packed {
    func_t       func;
    logic        restart;
    logic [7:0]  chunk_index;
    logic [7:0]  chunk_total;
    logic [7:0]  data_length;
    logic [7:0]  data_byte;
    logic [15:0] read_address;
  } icr_item_t;

  // Result fields known at execution, before the store read data returns.
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] image_length;
    logic [7:0]       expected_next;
    logic             assembling;
    logic [15:0]      completed_images;
    logic [15:0]      discarded_images;
  } icr_res_t;

endpackage

### rtl/icr_if.sv
// Valid/ready channel interfaces for the input words and the result words.
interface icr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  chunk_index;
  logic [7:0]  chunk_total;
  logic [7:0]  data_length;
  logic [7:0]  data_byte;
  logic [15:0] read_address;

  modport source (
    output valid, func, chunk_index, chunk_total, data_length, data_byte, read_address,
    input  ready
  );
  modport sink (
    input  valid, func, chunk_index, chunk_total, data_length, data_byte, read_address,
    output ready
  );
endinterface

interface icr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [16:0] image_length;
  logic [7:0]  read_byte;
  logic [7:0]  expected_next;
  logic        assembling;
  logic [15:0] completed_images;
  logic [15:0] discarded_images;

  modport source (
    output valid, status, image_length, read_byte, expected_next, assembling,
           completed_images, discarded_images,
    input  ready
  );
  modport sink (
    input  valid, status, image_length, read_byte, expected_next, assembling,
           completed_images, discarded_images,
    output ready
  );
endinterface

### rtl/icr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module icr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/icr_front.sv
// Front part: accepts input words, classifies them and queues them for the back.
module icr_front (
  input  logic              clk,
  input  logic              rst_n,
  icr_in_if.sink            in_chan,
  output icr_pkg::icr_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import icr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  icr_item_t        slot_r [QUEUE_DEPTH];
  icr_item_t        new_item;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;

  assign in_chan.ready = (count_r != CNT_FULL);
  assign push          = in_chan.valid && in_chan.ready;

  // A header with index zero restarts assembly; flag it here so the back
  // does not have to decode it.
  always_comb begin
    new_item.func         = in_chan.func;
    new_item.restart      = (in_chan.func == FUNC_HEADER) && (in_chan.chunk_index == 8'd0);
    new_item.chunk_index  = in_chan.chunk_index;
    new_item.chunk_total  = in_chan.chunk_total;
    new_item.data_length  = in_chan.data_length;
    new_item.data_byte    = in_chan.data_byte;
    new_item.read_address = in_chan.read_address;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, q_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

endmodule

### rtl/icr_back.sv
// Back part: runs the assembly state machine, the image store and the result stages.
module icr_back #(
  parameter int unsigned BUFFER_BYTES = icr_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  icr_pkg::icr_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  icr_out_if.source          out_chan
);
  import icr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(BUFFER_BYTES);
  localparam logic [POS_W:0]   LIMIT_EXT = (POS_W + 1)'(BUFFER_BYTES);

  // Assembly state.
  logic [POS_W-1:0] wpos_r, wpos_nxt;
  logic             in_prog_r, in_prog_nxt;
  logic [7:0]       total_r, total_nxt;
  logic [7:0]       next_r, next_nxt;
  logic [7:0]       pending_r, pending_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [15:0]      cc_r, cc_nxt;
  logic [15:0]      dc_r, dc_nxt;
  logic [15:0]      timeout_r;

  // Execution helpers.
  logic             eff_inprog;
  logic [POS_W-1:0] eff_wpos;
  logic [7:0]       eff_total;
  logic [7:0]       eff_next;
  logic [7:0]       next_inc;
  logic [POS_W-1:0] wpos_inc;
  logic [15:0]      idle_inc;
  logic             hdr_ok;
  logic             byte_ok;
  logic             rd_in_range;
  logic             do_clear;
  logic             do_we;
  logic             do_re;
  icr_res_t         res_nxt;

  // Pipeline control.
  logic             exec;
  logic             s1_adv;
  logic             out_free;
  logic             s1_valid_r;
  icr_res_t         s1_res_r;
  logic             s1_rd_ok_r;
  logic             out_valid_r;
  icr_res_t         out_res_r;
  logic [7:0]       out_byte_r;
  logic [7:0]       ram_rdata;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign exec     = q_valid && (!s1_valid_r || s1_adv);
  assign q_pop    = exec;

  always_comb begin
    eff_inprog  = q_item.restart | in_prog_r;
    eff_wpos    = q_item.restart ? '0 : wpos_r;
    eff_total   = q_item.restart ? q_item.chunk_total : total_r;
    eff_next    = q_item.restart ? 8'd0 : next_r;
    next_inc    = eff_next + 8'd1;
    wpos_inc    = wpos_r + POS_W'(1);
    idle_inc    = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
    hdr_ok      = eff_inprog && (q_item.chunk_index == eff_next) &&
                  (q_item.chunk_total == eff_total) &&
                  (({1'b0, eff_wpos} + {{(POS_W - 7){1'b0}}, q_item.data_length}) <= LIMIT_EXT);
    byte_ok     = in_prog_r && (pending_r != 8'd0) && (wpos_r < LIMIT_POS);
    rd_in_range = ({1'b0, q_item.read_address} < LIMIT_POS);

    wpos_nxt    = wpos_r;
    in_prog_nxt = in_prog_r;
    total_nxt   = total_r;
    next_nxt    = next_r;
    pending_nxt = pending_r;
    idle_nxt    = idle_r;
    cc_nxt      = cc_r;
    dc_nxt      = dc_r;
    do_clear    = 1'b0;
    do_we       = 1'b0;
    do_re       = 1'b0;
    res_nxt.status       = ST_IDLE;
    res_nxt.image_length = '0;

    unique case (q_item.func)
      FUNC_HEADER: begin
        // Any header drops the rest of an unfinished chunk.
        pending_nxt = 8'd0;
        in_prog_nxt = eff_inprog;
        wpos_nxt    = eff_wpos;
        total_nxt   = eff_total;
        next_nxt    = eff_next;
        if (hdr_ok) begin
          next_nxt       = next_inc;
          pending_nxt    = q_item.data_length;
          idle_nxt       = 16'd0;
          res_nxt.status = ST_HDR_OK;
          if ((q_item.data_length == 8'd0) && (next_inc == eff_total)) begin
            res_nxt.status       = ST_COMPLETE;
            res_nxt.image_length = eff_wpos;
            cc_nxt               = cc_r + 16'd1;
            do_clear             = 1'b1;
          end
        end else begin
          res_nxt.status = ST_HDR_REJ;
        end
      end
      FUNC_DATA: begin
        if (byte_ok) begin
          do_we          = 1'b1;
          wpos_nxt       = wpos_inc;
          pending_nxt    = pending_r - 8'd1;
          res_nxt.status = ST_STORED;
          if ((pending_r == 8'd1) && (next_r == total_r)) begin
            res_nxt.status       = ST_COMPLETE;
            res_nxt.image_length = wpos_inc;
            cc_nxt               = cc_r + 16'd1;
            do_clear             = 1'b1;
          end
        end else begin
          res_nxt.status = ST_IGNORED;
        end
      end
      FUNC_TICK: begin
        if (in_prog_r) begin
          idle_nxt = idle_inc;
          if (idle_inc > timeout_r) begin
            res_nxt.status = ST_TIMEOUT;
            dc_nxt         = dc_r + 16'd1;
            do_clear       = 1'b1;
          end
        end
      end
      FUNC_READ: begin
        res_nxt.status = ST_READ;
        do_re          = rd_in_range;
      end
    endcase

    if (do_clear) begin
      in_prog_nxt = 1'b0;
      wpos_nxt    = '0;
      total_nxt   = 8'd0;
      next_nxt    = 8'd0;
      pending_nxt = 8'd0;
    end

    res_nxt.expected_next    = next_nxt;
    res_nxt.assembling       = in_prog_nxt;
    res_nxt.completed_images = cc_nxt;
    res_nxt.discarded_images = dc_nxt;
  end

  icr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (exec && do_we),
    .waddr (wpos_r[AW-1:0]),
    .wdata (q_item.data_byte),
    .re    (exec && do_re),
    .raddr (q_item.read_address[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r      <= '0;
      in_prog_r   <= 1'b0;
      total_r     <= 8'd0;
      next_r      <= 8'd0;
      pending_r   <= 8'd0;
      idle_r      <= 16'd0;
      cc_r        <= 16'd0;
      dc_r        <= 16'd0;
      timeout_r   <= TIMEOUT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        wpos_r    <= wpos_nxt;
        in_prog_r <= in_prog_nxt;
        total_r   <= total_nxt;
        next_r    <= next_nxt;
        pending_r <= pending_nxt;
        idle_r    <= idle_nxt;
        cc_r      <= cc_nxt;
        dc_r      <= dc_nxt;
      end
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (exec) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The store read data is valid in the cycle after execution and is held
  // until the stage moves on, since no other read is issued meanwhile.
  always_ff @(posedge clk) begin
    if (exec) begin
      s1_res_r   <= res_nxt;
      s1_rd_ok_r <= do_re;
    end
    if (s1_adv) begin
      out_res_r  <= s1_res_r;
      out_byte_r <= s1_rd_ok_r ? ram_rdata : 8'd0;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_res_r.status;
  assign out_chan.image_length     = out_res_r.image_length;
  assign out_chan.read_byte        = out_byte_r;
  assign out_chan.expected_next    = out_res_r.expected_next;
  assign out_chan.assembling       = out_res_r.assembling;
  assign out_chan.completed_images = out_res_r.completed_images;
  assign out_chan.discarded_images = out_res_r.discarded_images;

endmodule

### rtl/image_chunk_reassembler_top.sv
// Top level of the image chunk reassembler: front, queue and back joined together.
//
//   Channel   Direction  Handshake            Word
//   in_chan   input      valid/ready          func, chunk fields, data byte, read address
//   out_chan  output     valid/ready          status, length, read byte, progress, counters
//   cfg_*     input      write enable only    timeout_ms
//
// One word is taken per clock cycle while the output is not stalled. A word
// is written into the queue when accepted, executes from the queue head into
// the execute stage register and moves on to the output register, which offers its result.
// The assembly state and the store write port are updated once per word,
// which sets the sustained rate at one word per cycle while out_chan is not stalled.
// Reset is synchronous and active low; the image store is not cleared and
// needs no clearing pass, so the block is ready in the cycle after reset.
// A stalled result holds in the output register while the execute stage and
// the two-entry queue keep taking words until they fill, four words in all.
module image_chunk_reassembler_top #(
  parameter int unsigned BUFFER_BYTES = icr_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  icr_in_if.sink      in_chan,
  icr_out_if.source   out_chan,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import icr_pkg::*;

  // Words leave the front in order and wait in its queue until the back
  // has room in its execute stage.
  icr_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  icr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // The back owns all assembly state, the timeout register and the store.
  icr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_chan    (out_chan)
  );

endmodule

### rtl/icr_checker.sv
// Port-level checker for the image chunk reassembler and its bind statement.
module icr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [16:0] image_length,
  input logic [7:0]  read_byte,
  input logic [7:0]  expected_next,
  input logic        assembling,
  input logic [15:0] completed_images,
  input logic [15:0] discarded_images
);
  import icr_pkg::*;

  logic [15:0] last_cc_r;
  logic [15:0] last_dc_r;
  logic [15:0] cc_exp;
  logic [15:0] dc_exp;
  logic        out_fire;

  assign out_fire = out_valid && out_ready;
  assign cc_exp   = (status == ST_COMPLETE) ? last_cc_r + 16'd1 : last_cc_r;
  assign dc_exp   = (status == ST_TIMEOUT) ? last_dc_r + 16'd1 : last_dc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cc_r <= 16'd0;
      last_dc_r <= 16'd0;
    end else if (out_fire) begin
      last_cc_r <= completed_images;
      last_dc_r <= discarded_images;
    end
  end

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result keeps all of its fields.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(image_length) &&
      $stable(read_byte) && $stable(expected_next) && $stable(assembling) &&
      $stable(completed_images) && $stable(discarded_images))
    else $error("stalled result changed");

  // The completed count steps by one exactly on a complete result.
  a_complete_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> completed_images == cc_exp)
    else $error("completed count out of step with results");

  // The discarded count steps by one exactly on a timeout result.
  a_discard_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> discarded_images == dc_exp)
    else $error("discarded count out of step with results");

  // A finished or discarded image leaves no assembly behind.
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && (status == ST_COMPLETE || status == ST_TIMEOUT) |->
      !assembling && expected_next == 8'd0)
    else $error("assembly not cleared after complete or timeout");

endmodule

bind image_chunk_reassembler_top icr_checker u_icr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .status           (out_chan.status),
  .image_length     (out_chan.image_length),
  .read_byte        (out_chan.read_byte),
  .expected_next    (out_chan.expected_next),
  .assembling       (out_chan.assembling),
  .completed_images (out_chan.completed_images),
  .discarded_images (out_chan.discarded_images)
);
